FILE: design/ipv4pc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4pc_pkg
// Shared types, character codes and limits for the IPv4 prefix string checker.
// ----------------------------------------------------------------------------
package ipv4pc_pkg;

  // Result codes, in order of the verdict table
  typedef enum logic [3:0] {
    RC_OK        = 4'd0,
    RC_EMPTY     = 4'd1,
    RC_LENGTH    = 4'd2,
    RC_NOT_DIGIT = 4'd3,
    RC_COLON     = 4'd4,
    RC_TWO_SLASH = 4'd5,
    RC_BAD_ADDR  = 4'd6,
    RC_NO_PREFIX = 4'd7,
    RC_PFX_RANGE = 4'd8
  } result_code_t;

  // Prefix reader phase (atoi style)
  typedef enum logic [3:0] {
    PH_SPACE  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } prefix_phase_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam int LEN_MIN     = 9;
  localparam int LEN_MAX     = 21;
  localparam int CNT_SAT     = 22;
  localparam int PFX_LEN_SAT = 31;
  localparam int PFX_MAX     = 32;
  localparam int PFX_SAT     = 33;
  localparam int OCTET_MAX   = 255;
  localparam int DOTS_FULL   = 3;

  typedef struct packed {
    logic [4:0]    char_count;
    result_code_t  first_error;
    logic          slash_seen;
    logic [7:0]    octet_value;
    logic [2:0]    octet_count;
    logic          digit_seen;
    logic          address_bad;
    logic [4:0]    prefix_chars;
    prefix_phase_t prefix_phase;
    logic          prefix_negative;
    logic [5:0]    prefix_magnitude;
  } scan_state_t;

  // Idle scan state, between strings and after reset
  localparam scan_state_t SCAN_IDLE = '{
    char_count:       5'd0,
    first_error:      RC_OK,
    slash_seen:       1'b0,
    octet_value:      8'd0,
    octet_count:      3'd0,
    digit_seen:       1'b0,
    address_bad:      1'b0,
    prefix_chars:     5'd0,
    prefix_phase:     PH_SPACE,
    prefix_negative:  1'b0,
    prefix_magnitude: 6'd0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

FILE: design/ipv4pc_char_if.sv
// ----------------------------------------------------------------------------
// ipv4pc_char_if
// Character channel: one string byte per transfer, end mark on the NUL item.
// ----------------------------------------------------------------------------
interface ipv4pc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

FILE: design/ipv4pc_result_if.sv
// ----------------------------------------------------------------------------
// ipv4pc_result_if
// Result channel: one verdict code per string.
// ----------------------------------------------------------------------------
interface ipv4pc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] result_code;

  modport source (output valid, output result_code, input ready);
  modport sink   (input valid, input result_code, output ready);
endinterface

FILE: design/ipv4_prefix_string_checker_top.sv
// ----------------------------------------------------------------------------
// ipv4_prefix_string_checker_top
// Validates "a.b.c.d/p" strings streamed one byte per transfer.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                        | transfers
//  ---------+-----+--------------------------------+---------------------------
//  chars    | in  | char_byte[7:0], end_of_string  | one per character + end
//  results  | out | result_code[3:0]               | one per end-marked item
//
//  Every character transfer updates the scan registers in the same cycle,
//  so a character is taken each clock while chars.ready is high; the scan state
//  is held in a single register stage.
//  The end-marked item loads the verdict into the result register, which
//  shows it from the next cycle, and clears the scan state for the next string.
//  chars.ready is low only during rst, or while a result is held and results.ready is low.
//  rst is synchronous, active high; it clears the scan state and the result
//  valid flag, and holds chars.ready low.
//
module ipv4_prefix_string_checker_top (
  input logic              clk,
  input logic              rst,
  ipv4pc_char_if.sink      chars,
  ipv4pc_result_if.source  results
);
  import ipv4pc_pkg::*;

  scan_state_t  scan_state;
  result_code_t verdict;
  result_code_t code;
  logic         out_valid;
  logic         in_fire;
  logic         take_char;
  logic         take_end;

  // Result register frees as it is read, so no bubble between strings
  assign chars.ready = !rst && (!out_valid || results.ready);
  assign in_fire     = chars.valid && chars.ready;
  assign take_char   = in_fire && !chars.end_of_string;
  assign take_end    = in_fire && chars.end_of_string;

  ipv4pc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take_char),
    .clear     (take_end),
    .char_byte (chars.char_byte),
    .state     (scan_state)
  );

  // Verdict reads the state before the end item clears it
  ipv4pc_verdict u_verdict (
    .state (scan_state),
    .code  (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_end) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (take_end) begin
      code <= verdict;
    end
  end

  assign results.valid       = out_valid;
  assign results.result_code = 4'(code);

`ifndef SYNTHESIS
  // End-marked transfer always produces a result next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready && chars.end_of_string) |=> results.valid)
    else $error("end of string did not raise a result");

  // A new result only ever follows an end-marked transfer
  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(chars.valid && chars.ready && chars.end_of_string))
    else $error("result raised without an end of string");

  // Scan state is cleared for the next string
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready && chars.end_of_string) |=>
      (scan_state.char_count == 5'd0 && !scan_state.slash_seen &&
       scan_state.first_error == RC_OK))
    else $error("scan state not cleared after end of string");
`endif

endmodule

FILE: design/ipv4pc_scan.sv
// ----------------------------------------------------------------------------
// ipv4pc_scan
// Per-character scan state: length, scan errors, address and prefix parsers.
// ----------------------------------------------------------------------------
module ipv4pc_scan (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic                     clear,
  input  logic [7:0]               char_byte,
  output ipv4pc_pkg::scan_state_t  state
);
  import ipv4pc_pkg::*;

  scan_state_t state_next;
  logic [3:0]  digit_val;
  logic        c_digit;
  logic [11:0] octet_prod;
  logic [8:0]  mag_prod;

  assign c_digit    = is_digit(char_byte);
  assign digit_val  = char_byte[3:0];
  assign octet_prod = 12'(state.octet_value) * 12'd10 + 12'(digit_val);
  assign mag_prod   = 9'(state.prefix_magnitude) * 9'd10 + 9'(digit_val);

  always_comb begin
    state_next = state;
    if (clear) begin
      state_next = '0;
      state_next.first_error  = RC_OK;
      state_next.prefix_phase = PH_SPACE;
    end else if (take) begin
      // first scan error wins
      if (state.first_error == RC_OK) begin
        if (state.char_count == 5'd0 && !c_digit) begin
          state_next.first_error = RC_NOT_DIGIT;
        end else if (char_byte == CHAR_COLON) begin
          state_next.first_error = RC_COLON;
        end else if (char_byte == CHAR_SLASH && state.slash_seen) begin
          state_next.first_error = RC_TWO_SLASH;
        end
      end

      if (char_byte == CHAR_SLASH) begin
        if (!state.slash_seen) begin
          if (!state.digit_seen || state.octet_count != 3'(DOTS_FULL)) begin
            state_next.address_bad = 1'b1;
          end
          state_next.slash_seen = 1'b1;
        end
      end else if (state.slash_seen) begin
        if (state.prefix_chars < 5'(PFX_LEN_SAT)) begin
          state_next.prefix_chars = state.prefix_chars + 5'd1;
        end
        if (state.prefix_phase == PH_SPACE && is_space(char_byte)) begin
          // leading whitespace skipped
        end else if (state.prefix_phase == PH_SPACE &&
                     (char_byte == CHAR_PLUS || char_byte == CHAR_MINUS)) begin
          state_next.prefix_negative = (char_byte == CHAR_MINUS);
          state_next.prefix_phase    = PH_SIGN;
        end else if (state.prefix_phase != PH_STOP) begin
          if (c_digit) begin
            state_next.prefix_magnitude = (mag_prod > 9'(PFX_SAT)) ? 6'(PFX_SAT)
                                                                  : mag_prod[5:0];
            state_next.prefix_phase = PH_DIGITS;
          end else begin
            state_next.prefix_phase = PH_STOP;
          end
        end
      end else begin
        if (c_digit) begin
          if ((state.digit_seen && state.octet_value == 8'd0) ||
              octet_prod > 12'(OCTET_MAX)) begin
            state_next.address_bad = 1'b1;
          end else begin
            state_next.octet_value = octet_prod[7:0];
            state_next.digit_seen  = 1'b1;
          end
        end else if (char_byte == CHAR_DOT) begin
          if (!state.digit_seen || state.octet_count >= 3'(DOTS_FULL)) begin
            state_next.address_bad = 1'b1;
          end else begin
            state_next.octet_count = state.octet_count + 3'd1;
            state_next.digit_seen  = 1'b0;
            state_next.octet_value = 8'd0;
          end
        end else begin
          state_next.address_bad = 1'b1;
        end
      end

      if (state.char_count < 5'(CNT_SAT)) begin
        state_next.char_count = state.char_count + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/ipv4pc_verdict.sv
// ----------------------------------------------------------------------------
// ipv4pc_verdict
// Turns the scan state at the end mark into one result code, by precedence.
// ----------------------------------------------------------------------------
module ipv4pc_verdict (
  input  ipv4pc_pkg::scan_state_t  state,
  output ipv4pc_pkg::result_code_t code
);
  import ipv4pc_pkg::*;

  logic addr_bad;
  logic pfx_out;

  // address still open when no slash came: close it here
  assign addr_bad = state.address_bad |
                    (!state.slash_seen &
                     (!state.digit_seen | (state.octet_count != 3'(DOTS_FULL))));

  assign pfx_out = (state.prefix_negative && state.prefix_magnitude != 6'd0) ||
                   (state.prefix_magnitude > 6'(PFX_MAX));

  always_comb begin
    if (state.char_count == 5'd0) begin
      code = RC_EMPTY;
    end else if (state.char_count < 5'(LEN_MIN) || state.char_count > 5'(LEN_MAX)) begin
      code = RC_LENGTH;
    end else if (state.first_error != RC_OK) begin
      code = state.first_error;
    end else if (addr_bad) begin
      code = RC_BAD_ADDR;
    end else if (!state.slash_seen || state.prefix_chars == 5'd0) begin
      code = RC_NO_PREFIX;
    end else if (pfx_out) begin
      code = RC_PFX_RANGE;
    end else begin
      code = RC_OK;
    end
  end

endmodule

FILE: bench/ipv4_prefix_string_checker_top_test.sv
// ----------------------------------------------------------------------------
// ipv4_prefix_string_checker_top_test
// Streams text strings into the checker one byte per transfer and compares
// each verdict code with a cycle-free scoreboard model of the scan. Directed
// strings cover the length bounds, every verdict and the parser corner cases.
// Random address-like strings, some of them mutated and some pure noise, follow
// under three idling profiles and one long result-side hold-off.
// ----------------------------------------------------------------------------
module ipv4_prefix_string_checker_top_test;
  import ipv4pc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
  localparam int HOLD_CYCLES  = 200;     // long result hold-off
  localparam int DRAIN_CYCLES = 20;      // settle time after the last verdict

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipv4pc_char_if   chars_bus ();
  ipv4pc_result_if results_bus ();

  ipv4_prefix_string_checker_top DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_bus),
    .results (results_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idling profile, in percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Bookkeeping
  int error_count = 0;
  int chars_sent  = 0;
  int cycle_count = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;

  // Verdicts still owed by the block, oldest first
  result_code_t expected_codes[$];

  // Bytes of the string being sent (terminator not included)
  logic [7:0] text_buf[$];

  // --------------------------------------------------------------------------
  // Scoreboard copy of the scan state
  // --------------------------------------------------------------------------
  logic [4:0]    n_chars    = '0;
  result_code_t  scan_err   = RC_OK;   // RC_OK doubles as "no scan error yet"
  logic          seen_slash = 1'b0;
  logic [7:0]    oct_val    = '0;
  logic [2:0]    n_dots     = '0;
  logic          have_digit = 1'b0;
  logic          addr_bad   = 1'b0;
  logic [4:0]    pfx_len    = '0;
  prefix_phase_t pfx_phase  = PH_SPACE;
  logic          pfx_neg    = 1'b0;
  logic [5:0]    pfx_mag    = '0;

  function automatic logic is_decimal(input logic [7:0] c);
    return c inside {[CHAR_ZERO:CHAR_NINE]};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
  endfunction

  // Advance the scan model by one accepted item; an end-marked item yields
  // the verdict and returns the model to its idle state.
  task automatic predict_verdict(input logic [7:0] c, input logic eos);
    result_code_t code;
    int acc;
    if (eos) begin
      // an address never closed by a slash is judged here
      if (!seen_slash && (!have_digit || n_dots != DOTS_FULL))
        addr_bad = 1'b1;
      if (n_chars == 0)
        code = RC_EMPTY;
      else if (n_chars < LEN_MIN || n_chars > LEN_MAX)
        code = RC_LENGTH;
      else if (scan_err != RC_OK)
        code = scan_err;
      else if (addr_bad)
        code = RC_BAD_ADDR;
      else if (!seen_slash || pfx_len == 0)
        code = RC_NO_PREFIX;
      else if ((pfx_neg && pfx_mag != 0) || pfx_mag > PFX_MAX)
        code = RC_PFX_RANGE;
      else
        code = RC_OK;
      expected_codes.push_back(code);
      n_chars    = '0;
      scan_err   = RC_OK;
      seen_slash = 1'b0;
      oct_val    = '0;
      n_dots     = '0;
      have_digit = 1'b0;
      addr_bad   = 1'b0;
      pfx_len    = '0;
      pfx_phase  = PH_SPACE;
      pfx_neg    = 1'b0;
      pfx_mag    = '0;
    end else begin
      // scan errors: only the first one sticks
      if (scan_err == RC_OK) begin
        if (n_chars == 0 && !is_decimal(c))
          scan_err = RC_NOT_DIGIT;
        else if (c == CHAR_COLON)
          scan_err = RC_COLON;
        else if (c == CHAR_SLASH && seen_slash)
          scan_err = RC_TWO_SLASH;
      end

      if (c == CHAR_SLASH) begin
        if (!seen_slash) begin
          if (!have_digit || n_dots != DOTS_FULL)
            addr_bad = 1'b1;
          seen_slash = 1'b1;
        end
      end else if (seen_slash) begin
        // prefix, read the atoi way
        if (pfx_len < PFX_LEN_SAT)
          pfx_len = pfx_len + 1'b1;
        if (pfx_phase == PH_SPACE && is_blank(c)) begin
          // skip leading whitespace
        end else if (pfx_phase == PH_SPACE && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
          pfx_neg   = (c == CHAR_MINUS);
          pfx_phase = PH_SIGN;
        end else if (pfx_phase != PH_STOP) begin
          if (is_decimal(c)) begin
            acc       = int'(pfx_mag) * 10 + int'(c - CHAR_ZERO);
            pfx_mag   = (acc > PFX_SAT) ? 6'(PFX_SAT) : 6'(acc);
            pfx_phase = PH_DIGITS;
          end else begin
            pfx_phase = PH_STOP;
          end
        end
      end else begin
        // dotted address: four octets, no leading zeros, each up to 255
        if (is_decimal(c)) begin
          acc = int'(oct_val) * 10 + int'(c - CHAR_ZERO);
          if (have_digit && oct_val == 0)
            addr_bad = 1'b1;          // leading zero
          else if (acc > OCTET_MAX)
            addr_bad = 1'b1;
          else begin
            oct_val    = 8'(acc);
            have_digit = 1'b1;
          end
        end else if (c == CHAR_DOT) begin
          if (!have_digit || n_dots >= DOTS_FULL)
            addr_bad = 1'b1;
          else begin
            n_dots     = n_dots + 1'b1;
            have_digit = 1'b0;
            oct_val    = '0;
          end
        end else begin
          addr_bad = 1'b1;
        end
      end

      if (n_chars < CNT_SAT)
        n_chars = n_chars + 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one item, with an optional random gap first, and hold it until the
  // transfer. valid stays high afterwards so back-to-back items need no
  // second assignment in the same step.
  task automatic push_char(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      chars_bus.valid <= 1'b0;
      @(posedge clk);
    end
    chars_bus.valid         <= 1'b1;
    chars_bus.char_byte     <= c;
    chars_bus.end_of_string <= eos;
    @(posedge clk);
    while (!chars_bus.ready)
      @(posedge clk);
    chars_sent++;
    predict_verdict(c, eos);
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++)
      text_buf.push_back(s[i]);
  endtask

  // Send the buffered bytes, then the NUL terminator with the end mark
  task automatic send_buf();
    foreach (text_buf[i])
      push_char(text_buf[i], 1'b0);
    push_char(8'h00, 1'b1);
  endtask

  task automatic send_text(input string s);
    load_text(s);
    send_buf();
  endtask

  // --------------------------------------------------------------------------
  // Random string source: mostly address/prefix shaped with random content,
  // some mutated, some pure noise
  // --------------------------------------------------------------------------
  task automatic make_random_text();
    string s;
    string alphabet;
    int n;
    int pick;
    int pos;
    logic [7:0] b;
    alphabet = "0123456789./:+- \t";
    if ($urandom_range(99) < 12) begin
      text_buf.delete();
      n = $urandom_range(24);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1))
          b = 8'($urandom_range(255));
        else
          b = alphabet[$urandom_range(alphabet.len() - 1)];
        text_buf.push_back(b);
      end
    end else begin
      s = "";
      for (int i = 0; i < 4; i++) begin
        pick = $urandom_range(99);
        if (pick < 85)
          s = {s, $sformatf("%0d", $urandom_range(255))};
        else if (pick < 92)
          s = {s, $sformatf("%0d", $urandom_range(999, 256))};
        else
          s = {s, $sformatf("0%0d", $urandom_range(99))};
        if (i < 3)
          s = {s, "."};
      end
      if ($urandom_range(99) < 95)
        s = {s, "/"};
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1))
          s = {s, " "};
        else
          s = {s, "\t"};
      end
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(1))
          s = {s, "-"};
        else
          s = {s, "+"};
      end
      pick = $urandom_range(99);
      if (pick < 80)
        s = {s, $sformatf("%0d", $urandom_range(32))};
      else if (pick < 90)
        s = {s, $sformatf("%0d", $urandom_range(999, 33))};
      if ($urandom_range(99) < 10)
        s = {s, "x"};
      load_text(s);

      // broken sequences: overwrite, insert a colon or slash, drop a byte
      if ($urandom_range(99) < 30) begin
        n = $urandom_range(2, 1);
        for (int i = 0; i < n; i++) begin
          pos  = $urandom_range(text_buf.size() - 1);
          pick = $urandom_range(3);
          if (pick == 0)
            text_buf[pos] = 8'($urandom_range(255));
          else if (pick == 1)
            text_buf.insert(pos, CHAR_COLON);
          else if (pick == 2)
            text_buf.insert(pos, CHAR_SLASH);
          else if (text_buf.size() > 1)
            text_buf.delete(pos);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      results_bus.ready <= 1'b0;
      hold_left         <= 0;
    end else if (hold_start) begin
      results_bus.ready <= 1'b0;
      hold_left         <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      results_bus.ready <= 1'b0;
      hold_left         <= hold_left - 1;
    end else begin
      results_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Verdict check against the oldest expectation
  always @(posedge clk) begin
    result_code_t want;
    if (!rst && results_bus.valid && results_bus.ready) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected verdict: expected none, actual %0d",
                 $time, results_bus.result_code);
        error_count++;
      end else begin
        want = expected_codes.pop_front();
        if (results_bus.result_code !== want) begin
          $display("%0t: verdict mismatch: expected %0d, actual %0d",
                   $time, want, results_bus.result_code);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Length window 9..21, saturation of the character count, empty string
  task automatic test_length_bounds();
    send_text("");
    send_text("1.2.3.4/5");
    send_text("255.255.255.255/ +032");
    send_text("1.2.3.4/");
    send_text("255.255.255.255/ +0032");
    send_text("100.100.100.100/000000000000032");
  endtask

  // Scan errors and their ranking; length still wins over them
  task automatic test_scan_errors();
    send_text("a.2.3.4/24");
    send_text("12:3.4.5/24");
    send_text("1.2.3.4/2/4");
    send_text(":1.2.3.4/8");
    send_text("a:/");
  endtask

  // Address parser: octet range, leading zero, dot count, empty octet,
  // missing slash, nothing after the slash
  task automatic test_address_rules();
    send_text("1.2.3.256/24");
    send_text("01.2.3.4/24");
    send_text("1.2.3.4.5/24");
    send_text("1..2.3.4/24");
    send_text("10.20.30.40");
    send_text("10.2.3.4/");
    // zero byte inside the address, not end-marked: an ordinary bad char
    load_text("1.2.3.4/8");
    text_buf.insert(1, 8'h00);
    send_buf();
  endtask

  // Prefix reader: range, sign, negative zero, no digits, whitespace,
  // stop at the first non-digit, saturation, stray zero and all-ones bytes
  task automatic test_prefix_reader();
    send_text("1.2.3.4/33");
    send_text("1.2.3.4/-5");
    send_text("1.2.3.4/-0");
    send_text("1.2.3.4/ab");
    send_text("1.2.3.4/\t\n+12x9");
    send_text("1.2.3.4/999999");
    load_text("1.2.3.4/1");
    text_buf.push_back(8'h00);
    send_buf();
    load_text("1.2.3.4/");
    text_buf.push_back(8'hFF);
    send_buf();
  endtask

  task automatic test_random_strings(input int n_items);
    int stop_at;
    stop_at = chars_sent + n_items;
    while (chars_sent < stop_at) begin
      make_random_text();
      send_buf();
    end
  endtask

  // Results held back for a long stretch while strings keep coming: the
  // result register fills and the character input must stall
  task automatic test_result_backpressure();
    chars_bus.valid <= 1'b0;
    hold_start      <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 6; i++) begin
      make_random_text();
      send_buf();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    chars_bus.valid         = 1'b0;
    chars_bus.char_byte     = '0;
    chars_bus.end_of_string = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct <= 82;
    test_length_bounds();
    test_scan_errors();
    test_address_rules();
    test_prefix_reader();
    test_random_strings(300);

    // the other way round
    send_idle_pct = 82;
    recv_idle_pct <= 25;
    test_random_strings(325);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_result_backpressure();
    test_random_strings(300);

    chars_bus.valid <= 1'b0;
    while (expected_codes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_codes.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
